// File: sv/csv_line_tokenizer_unit_macros.svh
// ----------------------------------------------------------------------------
// CSV line tokenizer assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CSV_LINE_TOKENIZER_UNIT_MACROS_SVH
`define CSV_LINE_TOKENIZER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent.
`define CSVT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define CSVT_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");
`else
`define CSVT_ASSERT_IMPL(label, ante, cons)
`define CSVT_ASSERT_NEVER(label, cond)
`endif

`endif

// File: sv/csvt_pkg.sv
// ----------------------------------------------------------------------------
// CSV tokenizer package
// Constants, codes and transaction types shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam int HOLD_DEPTH  = 16;
  localparam int MAX_FIELDS  = 64;
  localparam int FIELD_W     = 6;
  localparam int FIELD_LIMIT = ((MAX_FIELDS - 1) > 63) ? 63 : (MAX_FIELDS - 1);
  localparam int HOLD_W      = $clog2(HOLD_DEPTH + 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int SEP_W  = 7;
  localparam int CNT_W  = 3;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [7:0] QUOTE_CH  = 8'h22;
  localparam logic [7:0] SPACE_CH  = 8'h20;
  localparam logic [7:0] TAB_CH    = 8'h09;
  localparam logic [7:0] LF_CH     = 8'h0a;
  localparam logic [7:0] CR_CH     = 8'h0d;
  localparam logic [7:0] TOP_LEGAL = 8'h7e;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_FIELD  = 2'd1,
    KIND_RECORD = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_QUOTE,
    ACT_DATA,
    ACT_FIELD,
    ACT_RECORD,
    ACT_ERROR
  } act_t;

  typedef enum logic [2:0] {
    REG_SEP_FIRST  = 3'd0,
    REG_SEP_SECOND = 3'd1,
    REG_SEP_THIRD  = 3'd2,
    REG_SEP_FOURTH = 3'd3,
    REG_SEP_COUNT  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [SEP_W-1:0] first;
    logic [SEP_W-1:0] second;
    logic [SEP_W-1:0] third;
    logic [SEP_W-1:0] fourth;
    logic [CNT_W-1:0] count;
  } sep_cfg_t;

  // One entry per input byte that yields results: flush spaces, then one result.
  typedef struct packed {
    logic [7:0]         data;
    kind_t              kind;
    logic [FIELD_W-1:0] fidx;
    logic               hdr;
    logic               ovf;
    logic [HOLD_W-1:0]  flush;
  } cmd_t;

endpackage

// File: sv/csvt_front.sv
// ----------------------------------------------------------------------------
// CSV tokenizer front end
// Accepts text bytes, tracks line state and queues at most one command per byte.
// ----------------------------------------------------------------------------
module csvt_front import csvt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     [7:0] in_byte,
  output logic     in_stall,
  input  sep_cfg_t sep_cfg,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic               sb_r, sb_nxt;
  logic               iq_r, iq_nxt;
  logic               id_r, id_nxt;
  logic               qp_r, qp_nxt;
  logic               ts_r, ts_nxt;
  logic               hd_r, hd_nxt;
  logic [HOLD_W-1:0]  held_r, held_nxt;
  logic [FIELD_W-1:0] fc_r, fc_nxt;

  logic       accept;
  logic       toggle_q, toggle_d, iq_eff;
  logic       is_blank, is_crlf, is_sep;
  logic [2:0] cnt_eff;
  act_t       act;
  logic       emit;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && emit;

  always_comb begin
    cnt_eff  = (sep_cfg.count > 3'd4) ? 3'd4 : sep_cfg.count;
    is_sep   = (cnt_eff >= 3'd1 && in_byte == {1'b0, sep_cfg.first})  ||
               (cnt_eff >= 3'd2 && in_byte == {1'b0, sep_cfg.second}) ||
               (cnt_eff >= 3'd3 && in_byte == {1'b0, sep_cfg.third})  ||
               (cnt_eff >= 3'd4 && in_byte == {1'b0, sep_cfg.fourth});
    is_crlf  = (in_byte == LF_CH) || (in_byte == CR_CH);
    is_blank = (in_byte == SPACE_CH) || (in_byte == TAB_CH) || is_crlf;
    toggle_d = qp_r && (in_byte == QUOTE_CH);
    toggle_q = qp_r && (in_byte != QUOTE_CH);
    iq_eff   = iq_r ^ toggle_q;

    // Classify the byte against the current line state.
    if (toggle_d) begin
      act = ACT_DATA;
    end else if (in_byte > TOP_LEGAL) begin
      act = ACT_ERROR;
    end else if (sb_r && is_blank) begin
      act = ACT_NONE;
    end else if (in_byte == QUOTE_CH) begin
      act = ACT_QUOTE;
    end else if (!is_crlf) begin
      act = (is_sep && !iq_eff && !id_r) ? ACT_FIELD : ACT_DATA;
    end else if (!iq_eff || id_r) begin
      act = ACT_RECORD;
    end else begin
      act = ACT_DATA;
    end
  end

  always_comb begin
    sb_nxt   = sb_r;
    iq_nxt   = iq_r;
    id_nxt   = id_r;
    qp_nxt   = qp_r;
    ts_nxt   = ts_r;
    hd_nxt   = hd_r;
    held_nxt = held_r;
    fc_nxt   = fc_r;
    emit     = 1'b0;
    q_cmd.data  = 8'h00;
    q_cmd.kind  = KIND_DATA;
    q_cmd.fidx  = fc_r;
    q_cmd.hdr   = !hd_r;
    q_cmd.ovf   = 1'b0;
    q_cmd.flush = '0;

    case (act)
      ACT_NONE: begin
      end
      ACT_QUOTE: begin
        sb_nxt = 1'b0;
        iq_nxt = iq_eff;
        qp_nxt = 1'b1;
      end
      ACT_DATA: begin
        sb_nxt = 1'b0;
        iq_nxt = iq_eff;
        id_nxt = id_r ^ toggle_d;
        qp_nxt = 1'b0;
        if (in_byte == SPACE_CH) begin
          // Spaces inside a token are held back until a non-space follows or the hold overflows.
          if (ts_r) begin
            if (held_r < HOLD_W'(HOLD_DEPTH)) begin
              held_nxt = held_r + 1'b1;
            end else begin
              emit        = 1'b1;
              q_cmd.data  = SPACE_CH;
              q_cmd.ovf   = 1'b1;
              q_cmd.flush = held_r;
              held_nxt    = '0;
            end
          end
        end else begin
          emit        = 1'b1;
          q_cmd.data  = in_byte;
          q_cmd.flush = held_r;
          held_nxt    = '0;
          ts_nxt      = 1'b1;
        end
      end
      ACT_FIELD: begin
        emit       = 1'b1;
        q_cmd.kind = KIND_FIELD;
        iq_nxt     = iq_eff;
        qp_nxt     = 1'b0;
        held_nxt   = '0;
        ts_nxt     = 1'b0;
        sb_nxt     = 1'b1;
        if (fc_r < FIELD_W'(FIELD_LIMIT)) begin
          fc_nxt = fc_r + 1'b1;
        end
      end
      ACT_RECORD, ACT_ERROR: begin
        emit       = 1'b1;
        q_cmd.kind = (act == ACT_RECORD) ? KIND_RECORD : KIND_ERROR;
        sb_nxt     = 1'b1;
        iq_nxt     = 1'b0;
        id_nxt     = 1'b0;
        qp_nxt     = 1'b0;
        ts_nxt     = 1'b0;
        held_nxt   = '0;
        fc_nxt     = '0;
        if (act == ACT_RECORD) begin
          hd_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r   <= 1'b1;
      iq_r   <= 1'b0;
      id_r   <= 1'b0;
      qp_r   <= 1'b0;
      ts_r   <= 1'b0;
      hd_r   <= 1'b0;
      held_r <= '0;
      fc_r   <= '0;
    end else if (accept) begin
      sb_r   <= sb_nxt;
      iq_r   <= iq_nxt;
      id_r   <= id_nxt;
      qp_r   <= qp_nxt;
      ts_r   <= ts_nxt;
      hd_r   <= hd_nxt;
      held_r <= held_nxt;
      fc_r   <= fc_nxt;
    end
  end

endmodule

// File: sv/csvt_queue.sv
// ----------------------------------------------------------------------------
// CSV tokenizer command queue
// Small FIFO that decouples the front end from the result sequencer.
// ----------------------------------------------------------------------------
module csvt_queue import csvt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t dout
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

// File: sv/csvt_back.sv
// ----------------------------------------------------------------------------
// CSV tokenizer result sequencer
// Expands each queued command into held spaces plus a final result.
// ----------------------------------------------------------------------------
module csvt_back import csvt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic [1:0]         out_kind,
  output logic [FIELD_W-1:0] out_field_index,
  output logic               out_is_header,
  output logic               out_trim_overflow,
  output logic               out_last
);

  logic               valid_r, valid_nxt;
  logic [HOLD_W-1:0]  sp_r, sp_nxt;
  logic [7:0]         byte_r, byte_nxt;
  kind_t              kind_r, kind_nxt;
  logic [FIELD_W-1:0] fidx_r, fidx_nxt;
  logic               hdr_r, hdr_nxt;
  logic               ovf_r, ovf_nxt;
  logic               last_r, last_nxt;
  logic               load;

  assign load = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    sp_nxt    = sp_r;
    byte_nxt  = byte_r;
    kind_nxt  = kind_r;
    fidx_nxt  = fidx_r;
    hdr_nxt   = hdr_r;
    ovf_nxt   = ovf_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    if (load) begin
      valid_nxt = q_valid;
      if (q_valid) begin
        fidx_nxt = q_cmd.fidx;
        hdr_nxt  = q_cmd.hdr;
        ovf_nxt  = q_cmd.ovf;
        if (sp_r != q_cmd.flush) begin
          // Held whitespace is always spaces, so only a count is kept.
          byte_nxt = SPACE_CH;
          kind_nxt = KIND_DATA;
          last_nxt = 1'b0;
          sp_nxt   = sp_r + 1'b1;
        end else begin
          byte_nxt = q_cmd.data;
          kind_nxt = q_cmd.kind;
          last_nxt = 1'b1;
          sp_nxt   = '0;
          q_pop    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sp_r    <= '0;
    end else begin
      valid_r <= valid_nxt;
      sp_r    <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    kind_r <= kind_nxt;
    fidx_r <= fidx_nxt;
    hdr_r  <= hdr_nxt;
    ovf_r  <= ovf_nxt;
    last_r <= last_nxt;
  end

  assign out_valid         = valid_r;
  assign out_byte          = byte_r;
  assign out_kind          = kind_r;
  assign out_field_index   = fidx_r;
  assign out_is_header     = hdr_r;
  assign out_trim_overflow = ovf_r;
  assign out_last          = last_r;

endmodule

// File: sv/csv_line_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// CSV line tokenizer
// Splits a byte stream into field data, field ends and record ends.
// ----------------------------------------------------------------------------
// Input channel: one text byte per transaction on in_byte (in_valid/in_stall).
// Result channel: out_* fields, out_last marks the final result of a byte.
// A byte yields no result (skipped blanks, held spaces, quotes), one result,
// or a run of held spaces followed by the byte itself, at most 17 results.
// Each byte's results pass through the command queue and the result register,
// which then delivers one result per cycle while out_stall is low.
// Bytes are taken at one per cycle as long as the four-entry command queue
// has room, so a byte that releases N held spaces yields N+1 results and
// the front end waits only once the queue fills up.
// When the receiver stalls, the current result holds and the queue fills;
// in_stall then rises until an entry has drained.
// Separators are set through the APB port (registers at byte addresses 0,
// 4, 8, 12 and the active count at 16); write them only while idle.
// Synchronous reset restores the default comma separator, clears the line
// state and the header flag, and empties the queue and result register.
// ----------------------------------------------------------------------------
`include "csv_line_tokenizer_unit_macros.svh"

module csv_line_tokenizer_unit import csvt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic [1:0]         out_kind,
  output logic [FIELD_W-1:0] out_field_index,
  output logic               out_is_header,
  output logic               out_trim_overflow,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  sep_cfg_t sep_r, sep_nxt;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  logic q_push, q_pop, q_full, q_valid;
  cmd_t q_din, q_dout;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    sep_nxt = sep_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_SEP_FIRST:  sep_nxt.first  = pwdata[SEP_W-1:0];
        REG_SEP_SECOND: sep_nxt.second = pwdata[SEP_W-1:0];
        REG_SEP_THIRD:  sep_nxt.third  = pwdata[SEP_W-1:0];
        REG_SEP_FOURTH: sep_nxt.fourth = pwdata[SEP_W-1:0];
        REG_SEP_COUNT:  sep_nxt.count  = pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SEP_FIRST:  prdata = DATA_W'(sep_r.first);
      REG_SEP_SECOND: prdata = DATA_W'(sep_r.second);
      REG_SEP_THIRD:  prdata = DATA_W'(sep_r.third);
      REG_SEP_FOURTH: prdata = DATA_W'(sep_r.fourth);
      REG_SEP_COUNT:  prdata = DATA_W'(sep_r.count);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r.first  <= SEP_W'(44);
      sep_r.second <= '0;
      sep_r.third  <= '0;
      sep_r.fourth <= '0;
      sep_r.count  <= CNT_W'(1);
    end else begin
      sep_r <= sep_nxt;
    end
  end

  csvt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_stall (in_stall),
    .sep_cfg  (sep_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_din)
  );

  csvt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  csvt_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_cmd             (q_dout),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_kind          (out_kind),
    .out_field_index   (out_field_index),
    .out_is_header     (out_is_header),
    .out_trim_overflow (out_trim_overflow),
    .out_last          (out_last)
  );

  // The queue must never be written while it is full.
  `CSVT_ASSERT_NEVER(a_queue_no_overrun, q_push && q_full)
  // Every result that is not the last of its byte is a released space.
  `CSVT_ASSERT_IMPL(a_flush_is_space, out_valid && !out_last,
                    out_kind == KIND_DATA && out_byte == SPACE_CH)
  // Field ends, record ends and errors always close their byte.
  `CSVT_ASSERT_IMPL(a_ctrl_is_last, out_valid && out_kind != KIND_DATA, out_last)

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// CSV line tokenizer testbench
// Sends byte streams through the tokenizer under several separator settings
// and compares every result against a cycle-free model of the token rules,
// with random bursts on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module testbench;
  import csvt_pkg::*;

  typedef struct {
    logic [7:0]         data;
    kind_t              kind;
    logic [FIELD_W-1:0] fidx;
    logic               hdr;
    logic               ovf;
    logic               last;
  } token_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_EVERY_THIRD, STALL_HEAVY} stall_style_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_byte;
  logic [1:0]         out_kind;
  logic [FIELD_W-1:0] out_field_index;
  logic               out_is_header;
  logic               out_trim_overflow;
  logic               out_last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  // Tokenizer model state and its copy of the separator registers.
  logic [SEP_W-1:0] sep_val [4] = '{7'h2c, 7'h00, 7'h00, 7'h00};
  logic [CNT_W-1:0] sep_active = 3'd1;
  bit               skip_blank = 1'b1;
  bit               quoted, doubled, quote_wait, token_open, hdr_seen;
  int               held_spaces, field_no;
  token_t           tokens_due[$];
  token_t           staged;
  bit               staged_valid;

  int  fail_count, results_seen, bytes_sent, settings_used;
  int  burst_left, long_hold;
  bit  sender_eager;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  csv_line_tokenizer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_kind(out_kind), .out_field_index(out_field_index),
    .out_is_header(out_is_header), .out_trim_overflow(out_trim_overflow),
    .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR: %s", msg);
  endfunction

  function void queue_token(token_t t);
    tokens_due = {tokens_due, t};
  endfunction

  // Results of one byte are staged so that the final one can carry last.
  function void stage_token(logic [7:0] data, kind_t kind, logic ovf);
    if (staged_valid) queue_token(staged);
    staged.data = (kind == KIND_DATA) ? data : 8'h00;
    staged.kind = kind;
    staged.fidx = field_no[FIELD_W-1:0];
    staged.hdr  = !hdr_seen;
    staged.ovf  = ovf;
    staged.last = 1'b0;
    staged_valid = 1'b1;
  endfunction

  function void clear_line();
    skip_blank  = 1'b1;
    quoted      = 1'b0;
    doubled     = 1'b0;
    quote_wait  = 1'b0;
    token_open  = 1'b0;
    held_spaces = 0;
    field_no    = 0;
  endfunction

  function bit is_separator(logic [7:0] b);
    int live;
    live = (sep_active > 4) ? 4 : sep_active;
    for (int i = 0; i < live; i++)
      if (b == {1'b0, sep_val[i]}) return 1'b1;
    return 1'b0;
  endfunction

  // Spaces after the first text byte of a token are held back and only
  // released by a following non-space byte, or all at once on overflow.
  function void add_text(logic [7:0] b);
    if (b == SPACE_CH) begin
      if (!token_open) return;
      if (held_spaces < HOLD_DEPTH) begin
        held_spaces++;
        return;
      end
      repeat (held_spaces) stage_token(SPACE_CH, KIND_DATA, 1'b1);
      stage_token(b, KIND_DATA, 1'b1);
      held_spaces = 0;
      return;
    end
    repeat (held_spaces) stage_token(SPACE_CH, KIND_DATA, 1'b0);
    held_spaces = 0;
    stage_token(b, KIND_DATA, 1'b0);
    token_open = 1'b1;
  endfunction

  function void tokenize_byte(logic [7:0] b);
    // A quote is resolved only by the byte after it.
    if (quote_wait) begin
      quote_wait = 1'b0;
      if (b == QUOTE_CH) begin
        add_text(QUOTE_CH);
        doubled = !doubled;
        return;
      end
      quoted = !quoted;
    end
    if (b > TOP_LEGAL) begin
      stage_token(8'h00, KIND_ERROR, 1'b0);
      clear_line();
      return;
    end
    if (skip_blank) begin
      if (b == SPACE_CH || b == TAB_CH || b == LF_CH || b == CR_CH) return;
      skip_blank = 1'b0;
    end
    if (b == QUOTE_CH) begin
      quote_wait = 1'b1;
    end else if (b != LF_CH && b != CR_CH) begin
      if (is_separator(b) && !quoted && !doubled) begin
        stage_token(8'h00, KIND_FIELD, 1'b0);
        if (field_no < FIELD_LIMIT) field_no++;
        held_spaces = 0;
        token_open  = 1'b0;
        skip_blank  = 1'b1;
      end else begin
        add_text(b);
      end
    end else if (!quoted || doubled) begin
      stage_token(8'h00, KIND_RECORD, 1'b0);
      hdr_seen = 1'b1;
      clear_line();
    end else begin
      add_text(b);
    end
  endfunction

  function logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h21, TOP_LEGAL));
    return (c == QUOTE_CH) ? 8'h61 : c;
  endfunction

  function logic [7:0] pick_separator();
    int live;
    live = (sep_active > 4) ? 4 : sep_active;
    if (live == 0) return 8'h2c;
    return {1'b0, sep_val[$urandom_range(0, live - 1)]};
  endfunction

  task send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0 && !sender_eager) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = (burst_left > 0) ? burst_left - 1 : 0;
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    staged_valid = 1'b0;
    tokenize_byte(b);
    if (staged_valid) begin
      staged.last = 1'b1;
      queue_token(staged);
    end
  endtask

  task drain_results();
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    // Bytes that produce nothing may still be in flight behind the last result.
    repeat (8) @(posedge clk);
  endtask

  task set_register(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] mask;
    mask = (idx == REG_SEP_COUNT) ? (1 << CNT_W) - 1 : (1 << SEP_W) - 1;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom() & ~mask) | (value & mask);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_SEP_COUNT) sep_active = value[CNT_W-1:0];
    else sep_val[idx] = value[SEP_W-1:0];
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (value & mask))
      note_failure($sformatf("register %s read back %0h, expected %0h",
                             idx.name(), prdata & mask, value & mask));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task apply_separators(input logic [SEP_W-1:0] s0, input logic [SEP_W-1:0] s1,
                        input logic [SEP_W-1:0] s2, input logic [SEP_W-1:0] s3,
                        input logic [CNT_W-1:0] n);
    set_register(REG_SEP_FIRST, DATA_W'(s0));
    set_register(REG_SEP_SECOND, DATA_W'(s1));
    set_register(REG_SEP_THIRD, DATA_W'(s2));
    set_register(REG_SEP_FOURTH, DATA_W'(s3));
    set_register(REG_SEP_COUNT, DATA_W'(n));
    settings_used++;
  endtask

  task test_directed_cases();
    logic [7:0] seq [25];
    // Blanks at line start, held space, quoted separator and CR, doubled quote
    // before LF, range extremes, illegal bytes and a quote resolved by LF.
    seq = '{SPACE_CH, TAB_CH, "a", SPACE_CH, "b", ",", QUOTE_CH, "x", ",", CR_CH,
            QUOTE_CH, QUOTE_CH, LF_CH, 8'h00, TOP_LEGAL, ",", SPACE_CH, 8'h7f,
            QUOTE_CH, LF_CH, QUOTE_CH, 8'hff, 8'h80, "z", CR_CH};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task test_hold_overflow();
    send_byte("t");
    repeat ($urandom_range(HOLD_DEPTH + 1, 2 * HOLD_DEPTH + 5)) send_byte(SPACE_CH);
    send_byte("u");
    // A buffer filled exactly is released in full by the next text byte.
    repeat (HOLD_DEPTH) send_byte(SPACE_CH);
    send_byte("v");
    send_byte(LF_CH);
  endtask

  task test_field_saturation();
    logic [7:0] sep;
    sep = pick_separator();
    send_byte("q");
    repeat (FIELD_LIMIT + 6) send_byte(sep);
    send_byte(LF_CH);
  endtask

  task test_random_text(input int budget);
    int stop, nf, pick;
    stop = bytes_sent + budget;
    while (bytes_sent < stop) begin
      if ($urandom_range(0, 15) == 0) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        nf = $urandom_range(1, 6);
        for (int f = 0; f < nf; f++) begin
          if (f > 0) send_byte(pick_separator());
          if ($urandom_range(0, 3) == 0) send_byte($urandom_range(0, 1) ? SPACE_CH : TAB_CH);
          case ($urandom_range(0, 5))
            0: ;
            1, 2: repeat ($urandom_range(1, 6)) send_byte(text_char());
            3: begin
              send_byte(QUOTE_CH);
              repeat ($urandom_range(0, 6)) begin
                pick = $urandom_range(0, 7);
                if (pick == 0) begin
                  send_byte(QUOTE_CH);
                  send_byte(QUOTE_CH);
                end else if (pick == 1) begin
                  send_byte(pick_separator());
                end else if (pick == 2) begin
                  send_byte($urandom_range(0, 1) ? CR_CH : LF_CH);
                end else if (pick == 3) begin
                  send_byte(SPACE_CH);
                end else begin
                  send_byte(text_char());
                end
              end
              send_byte(QUOTE_CH);
            end
            4: begin
              send_byte(text_char());
              repeat ($urandom_range(1, 20)) send_byte(SPACE_CH);
              send_byte(text_char());
            end
            default: repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 31)));
          endcase
          if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) send_byte(SPACE_CH);
        end
        case ($urandom_range(0, 2))
          0: send_byte(CR_CH);
          1: send_byte(LF_CH);
          default: begin
            send_byte(CR_CH);
            send_byte(LF_CH);
          end
        endcase
      end
    end
  endtask

  task test_backpressure();
    sender_eager = 1'b1;
    long_hold = 120;
    test_random_text(30);
    sender_eager = 1'b0;
    drain_results();
  endtask

  // Receiver: changes its stall style after each random span, and honours a
  // long hold request by keeping stall high for the whole requested hold.
  initial begin : receiver
    stall_style_t style;
    int span, tick;
    span = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        out_stall <= 1'b1;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
      end
      if (span == 0) begin
        style = stall_style_t'($urandom_range(0, 3));
        span = $urandom_range(16, 96);
      end
      span--;
      tick++;
      case (style)
        STALL_NONE:        out_stall <= 1'b0;
        STALL_LIGHT:       out_stall <= ($urandom_range(0, 3) == 0);
        STALL_EVERY_THIRD: out_stall <= (tick % 3 == 0);
        default:           out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    token_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (tokens_due.size() == 0) begin
        note_failure($sformatf("unexpected result: byte=%02h kind=%0d field=%0d",
                               out_byte, out_kind, out_field_index));
      end else begin
        want = tokens_due.pop_front();
        if (out_byte !== want.data || out_kind !== want.kind ||
            out_field_index !== want.fidx || out_is_header !== want.hdr ||
            out_trim_overflow !== want.ovf || out_last !== want.last)
          note_failure($sformatf({"result %0d: expected byte=%02h kind=%0d field=%0d ",
                                  "hdr=%b ovf=%b last=%b, got byte=%02h kind=%0d ",
                                  "field=%0d hdr=%b ovf=%b last=%b"},
                                 results_seen, want.data, want.kind, want.fidx,
                                 want.hdr, want.ovf, want.last, out_byte, out_kind,
                                 out_field_index, out_is_header, out_trim_overflow,
                                 out_last));
      end
    end
  end

  initial begin : watchdog
    #8000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default setting after reset: a single comma separator.
    test_directed_cases();
    test_hold_overflow();
    test_field_saturation();
    test_random_text(30);
    drain_results();

    apply_separators(7'h2c, 7'h3b, 7'h09, 7'h7c, 3'd4);
    test_backpressure();
    test_random_text(30);
    drain_results();

    // No active separator, with the register extremes loaded anyway.
    apply_separators(7'h7f, 7'h00, 7'h7f, 7'h00, 3'd0);
    test_random_text(25);
    drain_results();

    // A count above four behaves as four.
    apply_separators(SEP_W'($urandom_range(0, 127)), SEP_W'($urandom_range(0, 127)),
                     SEP_W'($urandom_range(0, 127)), SEP_W'($urandom_range(0, 127)),
                     3'd7);
    test_random_text(30);
    test_hold_overflow();
    drain_results();

    apply_separators(7'h20, 7'h00, 7'h7f, 7'h3b, 3'd2);
    test_random_text(25);
    drain_results();

    repeat (10) @(posedge clk);
    fail_count += tokens_due.size();
    $display("Tokenized %0d bytes into %0d results over %0d separator settings.",
             bytes_sent, results_seen, settings_used);
    $display("Covered quoting, doubled quotes, illegal bytes, space overflow, %s",
             "field saturation, register readback and a long output stall.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
